// ===== src/rle_pkg.sv =====
// Shared types, constants and helper functions for the run-length encoder.
package rle_pkg;

  // Decimal digit count of a positive value
  function automatic int dec_digits(input int v);
    int n;
    n = 1;
    while (v >= 10) begin
      v = v / 10;
      n++;
    end
    return n;
  endfunction

  // Run length limit and the counter width it needs
  localparam int MAX_RUN = 65535;
  localparam int RUN_W   = $clog2(MAX_RUN + 1);
  // Decimal digits of MAX_RUN; digit position index width
  localparam int DIGITS  = dec_digits(MAX_RUN);
  localparam int POS_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  // Compare width: must hold 9 * 10^(DIGITS-1), which is below 16 * 2^RUN_W
  localparam int CMP_W   = RUN_W + 4;

  // Command queue depth
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } rle_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_digit;
    logic       last_of_item;
  } rle_out_t;

  // One input item's work: up to two closed runs (the old run, then the new one)
  typedef struct packed {
    logic             has_old;
    logic [7:0]       old_byte;
    logic [RUN_W-1:0] old_cnt;
    logic             has_new;
    logic [7:0]       new_byte;
    logic [RUN_W-1:0] new_cnt;
  } rle_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BYTE,
    BK_DIGIT
  } bk_state_t;

  function automatic logic [CMP_W-1:0] pow10(input logic [POS_W-1:0] p);
    logic [CMP_W-1:0] v;
    v = CMP_W'(1);
    for (int i = 1; i < DIGITS; i++) begin
      if (p >= POS_W'(i)) begin
        v = CMP_W'(v * CMP_W'(10));
      end
    end
    return v;
  endfunction

endpackage

// ===== src/rle_front.sv =====
// Front end: takes bytes, tracks the open run, issues close commands.
module rle_front
  import rle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rle_in_t  in_data,
  input  logic     q_full,
  output logic     push,
  output rle_cmd_t cmd
);

  logic [7:0]       run_byte_r, run_byte_nxt;
  logic [RUN_W-1:0] run_len_r,  run_len_nxt;
  logic             run_open_r, run_open_nxt;

  logic             accept;
  logic             same;
  logic [RUN_W-1:0] new_len;
  logic             close_old;
  logic             close_new;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    same      = run_open_r && (in_data.in_byte == run_byte_r);
    new_len   = same ? RUN_W'(run_len_r + RUN_W'(1)) : RUN_W'(1);
    close_old = run_open_r && !same;
    close_new = (new_len >= RUN_W'(MAX_RUN)) || in_data.end_of_text;

    cmd.has_old  = close_old;
    cmd.old_byte = run_byte_r;
    cmd.old_cnt  = run_len_r;
    cmd.has_new  = close_new;
    cmd.new_byte = in_data.in_byte;
    cmd.new_cnt  = new_len;

    push = accept && (close_old || close_new);

    run_byte_nxt = run_byte_r;
    run_len_nxt  = run_len_r;
    run_open_nxt = run_open_r;
    if (accept) begin
      run_byte_nxt = in_data.in_byte;
      if (close_new) begin
        run_len_nxt  = '0;
        run_open_nxt = 1'b0;
      end else begin
        run_len_nxt  = new_len;
        run_open_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_byte_r <= '0;
      run_len_r  <= '0;
      run_open_r <= 1'b0;
    end else begin
      run_byte_r <= run_byte_nxt;
      run_len_r  <= run_len_nxt;
      run_open_r <= run_open_nxt;
    end
  end

endmodule

// ===== src/rle_q.sv =====
// Small command queue between the front end and the digit emitter.
module rle_q
  import rle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rle_cmd_t din,
  output logic     full,
  input  logic     pop,
  output rle_cmd_t dout,
  output logic     empty
);

  rle_cmd_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r, wptr_nxt;
  logic [Q_AW-1:0] rptr_r, rptr_nxt;
  logic [Q_CW-1:0] cnt_r,  cnt_nxt;

  assign full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? Q_AW'(wptr_r + Q_AW'(1)) : wptr_r;
    rptr_nxt = pop  ? Q_AW'(rptr_r + Q_AW'(1)) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = Q_CW'(cnt_r + Q_CW'(1));
    end else if (pop && !push) begin
      cnt_nxt = Q_CW'(cnt_r - Q_CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue pop while empty");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CW'(Q_DEPTH))
    else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wptr_r == rptr_r))
    else $error("queue pointers disagree with empty count");

endmodule

// ===== src/rle_back.sv =====
// Back end: expands run commands into a run byte and its decimal digits.
module rle_back
  import rle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rle_cmd_t head,
  input  logic     q_empty,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output rle_out_t out_data
);

  bk_state_t        st_r, st_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [RUN_W-1:0] rem_r, rem_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             last_r, last_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [7:0]       pend_byte_r, pend_byte_nxt;
  logic [RUN_W-1:0] pend_cnt_r, pend_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  rle_out_t         out_data_r, out_data_nxt;

  logic             adv;
  logic             want_load;
  logic [POS_W-1:0] top_pos;
  logic [3:0]       digit;
  logic [CMP_W-1:0] sub_v;
  logic [CMP_W-1:0] pw;
  logic [CMP_W-1:0] thr;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign adv       = !out_valid_r || out_ready;

  // Leading digit position and current digit by parallel compares
  always_comb begin
    top_pos = '0;
    for (int i = 1; i < DIGITS; i++) begin
      if (CMP_W'(rem_r) >= pow10(POS_W'(i))) begin
        top_pos = POS_W'(i);
      end
    end
    pw    = pow10(pos_r);
    digit = '0;
    sub_v = '0;
    for (int k = 1; k < 10; k++) begin
      thr = CMP_W'(pw * CMP_W'(k));
      if (CMP_W'(rem_r) >= thr) begin
        digit = 4'(k);
        sub_v = thr;
      end
    end
  end

  always_comb begin
    st_nxt        = st_r;
    byte_nxt      = byte_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    pend_vld_nxt  = pend_vld_r;
    pend_byte_nxt = pend_byte_r;
    pend_cnt_nxt  = pend_cnt_r;
    out_valid_nxt = adv ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    want_load     = 1'b0;
    pop           = 1'b0;

    unique case (st_r)
      BK_IDLE: begin
        want_load = 1'b1;
      end
      BK_BYTE: begin
        if (adv) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.out_byte     = byte_r;
          out_data_nxt.is_digit     = 1'b0;
          out_data_nxt.last_of_item = 1'b0;
          pos_nxt                   = top_pos;
          st_nxt                    = BK_DIGIT;
        end
      end
      BK_DIGIT: begin
        if (adv) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.out_byte     = 8'(ASCII_ZERO + {4'b0, digit});
          out_data_nxt.is_digit     = 1'b1;
          out_data_nxt.last_of_item = last_r && (pos_r == '0);
          rem_nxt                   = RUN_W'(rem_r - sub_v[RUN_W-1:0]);
          pos_nxt                   = POS_W'(pos_r - POS_W'(1));
          if (pos_r == '0) begin
            want_load = 1'b1;
          end
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase

    // Next run: pending second run first, else the queue head
    if (want_load) begin
      st_nxt = BK_IDLE;
      if (pend_vld_r) begin
        st_nxt       = BK_BYTE;
        byte_nxt     = pend_byte_r;
        rem_nxt      = pend_cnt_r;
        last_nxt     = 1'b1;
        pend_vld_nxt = 1'b0;
      end else if (!q_empty) begin
        pop    = 1'b1;
        st_nxt = BK_BYTE;
        if (head.has_old) begin
          byte_nxt      = head.old_byte;
          rem_nxt       = head.old_cnt;
          last_nxt      = !head.has_new;
          pend_vld_nxt  = head.has_new;
          pend_byte_nxt = head.new_byte;
          pend_cnt_nxt  = head.new_cnt;
        end else begin
          byte_nxt = head.new_byte;
          rem_nxt  = head.new_cnt;
          last_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    rem_r       <= rem_nxt;
    pos_r       <= pos_nxt;
    last_r      <= last_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
    out_data_r  <= out_data_nxt;
  end

  a_digit_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.is_digit) |->
      (out_data_r.out_byte >= ASCII_ZERO && out_data_r.out_byte <= 8'h39))
    else $error("digit result outside 0..9");

  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (st_r != BK_IDLE))
    else $error("pending run while emitter idle");

endmodule

// ===== src/rle_ascii_count_encoder_unit.sv =====
// Top level of the run-length encoder with decimal run counts.
//
// Input channel (in_valid/in_ready/in_data): one text byte per item, with
// end_of_text set on the final byte. The front end tracks the open run and
// can take one item every cycle while the command queue has room.
// Output channel (out_valid/out_ready/out_data): one result per cycle while
// out_ready is high, the run byte followed by its count in ASCII decimal,
// most significant digit first. last_of_item marks an item's final result.
//
// Path: with the emitter idle, a run closed by an item passes the command
// queue, the emitter's BK_BYTE state and the output register before its byte
// shows on out_data, then one digit per cycle while out_ready is high; runs
// still waiting ahead of it go out first. Rates: input one item per cycle
// while the queue has room. A run of count n emits its byte and one digit per
// decimal digit of n, so sustained input rate is set by the emitter: a 4-entry
// command queue absorbs the digit bursts and in_ready drops when it is full.
// Reset (synchronous, rst_n low): no run open, queue empty, out_valid low.
// Stall: with out_ready low the output register holds its item; the
// emitter and then the queue fill, after which in_ready goes low.
module rle_ascii_count_encoder_unit
  import rle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rle_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rle_out_t out_data
);

  logic     q_full;
  logic     q_empty;
  logic     push;
  logic     pop;
  rle_cmd_t push_cmd;
  rle_cmd_t head_cmd;

  // Run tracking: one command per item that closes a run
  rle_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Decouples byte intake from the digit bursts
  rle_q u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_cmd),
    .full  (q_full),
    .pop   (pop),
    .dout  (head_cmd),
    .empty (q_empty)
  );

  // Emits run byte and count digits through a registered output
  rle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_cmd),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
